// ===== sv/sobel_edge_magnitude_rgb_assert.svh =====
// Assertion macros for the Sobel edge block.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Same-cycle implication.
`define SEMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define SEMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/semr_pkg.sv =====
package semr_pkg;

    localparam int MAX_LINE_PIXELS = 1024;
    localparam int LINE_AW = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
    localparam int ROW_W = 17;
    localparam int SAT_LIMIT = 255;
    localparam int SQRT_SAT_LEVEL = 64771;

    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       frame_end;
    } edge_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQRT,
        ST_ROUND,
        ST_DONE
    } state_t;

endpackage

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// Sobel 3x3 edge magnitude on an RGB raster stream.
// pixel channel: valid/ready beats of pixel_beat (operation, red, green, blue).
// edge channel: valid/ready beats of edge_beat (three magnitudes, frame_end).
// Config: cfg_write_en with cfg_index 0 = frame_width, 1 = frame_height.
// Each result is round(sqrt(Gx^2 + Gy^2)) per channel, saturated at 255,
// zero padding outside the frame. Results lag the input by one row plus one
// pixel; after the last pixel send frame_width + 1 drain beats to flush.
// The last result of a frame has frame_end set and rewinds all counters.
// One beat at a time is processed: a drain ignored mid-frame is dropped in
// the idle state, a beat that gives no result passes the line store read,
// and one that does goes on through gradient/square, bit-serial square
// root, rounding and output load.
// A finished result sits in an output register; the next beat is taken
// while it waits, and a second result waits in the done state until the
// receiver takes the first.
// Reset clears counters, window and output valid; the line stores are not
// cleared and are only read where written, so no clearing pass is needed.
`include "sobel_edge_magnitude_rgb_assert.svh"

module sobel_edge_magnitude_rgb (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  semr_pkg::pixel_beat_t pixel_beat,
    output logic                  edge_valid,
    input  logic                  edge_ready,
    output semr_pkg::edge_beat_t  edge_beat,
    input  logic                  cfg_write_en,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data
);
    import semr_pkg::*;

    state_t state_reg, state_next;

    logic [10:0]        width_reg;
    logic [15:0]        height_reg;
    logic [LINE_AW-1:0] in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [LINE_AW-1:0] out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [8:0][23:0]   win_reg;
    logic [23:0]        px_reg;
    logic [23:0]        top_reg, mid_reg;
    logic               col0_reg;
    logic [2:0][15:0]   s_reg;
    logic [2:0]         sat_reg;
    logic [2:0][7:0]    root_reg;
    logic [2:0]         bit_reg;
    logic [2:0][7:0]    mag_reg;
    logic               edge_valid_reg;
    edge_beat_t         edge_beat_reg;

    logic [47:0]        line_mem [MAX_LINE_PIXELS];
    logic [47:0]        mem_rdata;
    logic               mem_we;
    logic [47:0]        mem_wdata;

    logic [10:0]        w_eff;
    logic [15:0]        h_eff;
    logic               draining;
    logic               accept;
    logic               drop;
    logic               emit;
    logic [23:0]        top, mid, bot;
    logic [8:0][23:0]   win_shift;
    logic               last;
    logic               load;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == 11'd0)
        begin
            w_eff = 11'd1;
        end
        else if (32'(width_reg) > MAX_LINE_PIXELS)
        begin
            w_eff = 11'(MAX_LINE_PIXELS);
        end
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    assign draining = in_row_reg >= ROW_W'(h_eff);
    assign accept   = pixel_valid && pixel_ready;
    assign drop     = !draining && (pixel_beat.operation == OP_DRAIN);

    assign top = (in_row_reg >= ROW_W'(2) && (in_row_reg - ROW_W'(2)) < ROW_W'(h_eff))
                 ? mem_rdata[47:24] : 24'd0;
    assign mid = (in_row_reg >= ROW_W'(1) && (in_row_reg - ROW_W'(1)) < ROW_W'(h_eff))
                 ? mem_rdata[23:0] : 24'd0;
    assign bot = px_reg;
    assign emit = (in_row_reg >= ROW_W'(2)) ||
                  (in_row_reg == ROW_W'(1) && in_col_reg != '0);

    assign mem_we    = (state_reg == ST_READ);
    assign mem_wdata = {mem_rdata[23:0], px_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[in_col_reg] <= mem_wdata;
        end
        mem_rdata <= line_mem[in_col_reg];
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_shift[r*3]   = win_reg[r*3+1];
            win_shift[r*3+1] = win_reg[r*3+2];
        end
        if (in_col_reg == '0)
        begin
            win_shift[2] = 24'd0;
            win_shift[5] = 24'd0;
            win_shift[8] = 24'd0;
        end
        else
        begin
            win_shift[2] = top;
            win_shift[5] = mid;
            win_shift[8] = bot;
        end
    end

    assign last = (out_row_reg > ROW_W'(h_eff - 16'd1)) ||
                  (out_row_reg == ROW_W'(h_eff - 16'd1) &&
                   32'(out_col_reg) >= 32'(w_eff) - 1);
    assign load = (state_reg == ST_DONE) && (!edge_valid_reg || edge_ready);

    function automatic logic [20:0] grad_energy(input logic [8:0][7:0] p);
        int gx;
        int gy;
        logic [9:0] ax;
        logic [9:0] ay;
        gx = int'(p[2]) + 2 * int'(p[5]) + int'(p[8])
           - int'(p[0]) - 2 * int'(p[3]) - int'(p[6]);
        gy = int'(p[6]) + 2 * int'(p[7]) + int'(p[8])
           - int'(p[0]) - 2 * int'(p[1]) - int'(p[2]);
        ax = 10'((gx < 0) ? -gx : gx);
        ay = 10'((gy < 0) ? -gy : gy);
        return 21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay));
    endfunction

    // window at the start of a row: only the right column is filled
    function automatic logic [8:0][23:0] col0_window(input logic [23:0] t,
                                                     input logic [23:0] m,
                                                     input logic [23:0] b);
        logic [8:0][23:0] w;
        w    = '0;
        w[2] = t;
        w[5] = m;
        w[8] = b;
        return w;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !drop)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = emit ? ST_GRAD : ST_IDLE;
            ST_GRAD:  state_next = ST_SQRT;
            ST_SQRT:  state_next = (bit_reg == 3'd0) ? ST_ROUND : ST_SQRT;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:  state_next = load ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixel_ready = (state_reg == ST_IDLE);
        edge_valid  = edge_valid_reg;
        edge_beat   = edge_beat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= 11'd1024;
            height_reg     <= 16'd1024;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            win_reg        <= '0;
            edge_valid_reg <= 1'b0;
            bit_reg        <= 3'd7;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                    CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
            if (load)
            begin
                edge_valid_reg <= 1'b1;
            end
            else if (edge_valid_reg && edge_ready)
            begin
                edge_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_READ:
                begin
                    if (!emit && in_col_reg == '0)
                    begin
                        win_reg <= col0_window(top, mid, bot);
                    end
                    else
                    begin
                        win_reg <= win_shift;
                    end
                    if (32'(in_col_reg) + 1 >= 32'(w_eff))
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + LINE_AW'(1);
                    end
                end
                ST_GRAD:
                begin
                    bit_reg <= 3'd7;
                    if (col0_reg)
                    begin
                        win_reg <= col0_window(top_reg, mid_reg, px_reg);
                    end
                end
                ST_SQRT:
                begin
                    bit_reg <= bit_reg - 3'd1;
                end
                ST_DONE:
                begin
                    if (load)
                    begin
                        if (last)
                        begin
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            win_reg     <= '0;
                        end
                        else if (32'(out_col_reg) + 1 >= 32'(w_eff))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + LINE_AW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        logic [20:0]     s;
        logic [8:0][7:0] p;
        logic [7:0]      trial;
        logic [16:0]     kk;
        if (accept)
        begin
            px_reg <= draining ? 24'd0 :
                      {pixel_beat.pixel_red, pixel_beat.pixel_green,
                       pixel_beat.pixel_blue};
        end
        if (state_reg == ST_READ)
        begin
            top_reg  <= top;
            mid_reg  <= mid;
            col0_reg <= (in_col_reg == '0);
        end
        for (int c = 0; c < 3; c++)
        begin
            if (state_reg == ST_GRAD)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    p[i] = win_reg[i][c*8 +: 8];
                end
                s = grad_energy(p);
                sat_reg[c]  <= (32'(s) >= SQRT_SAT_LEVEL);
                s_reg[c]    <= s[15:0];
                root_reg[c] <= 8'd0;
            end
            if (state_reg == ST_SQRT)
            begin
                trial = root_reg[c] | (8'd1 << bit_reg);
                if (16'(trial) * 16'(trial) <= s_reg[c])
                begin
                    root_reg[c] <= trial;
                end
            end
            if (state_reg == ST_ROUND)
            begin
                kk = 17'(16'(root_reg[c]) * 16'(root_reg[c])) + 17'(root_reg[c]);
                if (sat_reg[c])
                begin
                    mag_reg[c] <= 8'(SAT_LIMIT);
                end
                else if (17'(s_reg[c]) > kk)
                begin
                    mag_reg[c] <= root_reg[c] + 8'd1;
                end
                else
                begin
                    mag_reg[c] <= root_reg[c];
                end
            end
        end
        if (load)
        begin
            edge_beat_reg.edge_red   <= mag_reg[2];
            edge_beat_reg.edge_green <= mag_reg[1];
            edge_beat_reg.edge_blue  <= mag_reg[0];
            edge_beat_reg.frame_end  <= last;
        end
    end

    `SEMR_ASSERT_NOW(a_mem_write_in_read, clk, rst_n, mem_we, state_reg == ST_READ)
    `SEMR_ASSERT_NEXT(a_drop_stays_idle, clk, rst_n, accept && drop, state_reg == ST_IDLE)
    `SEMR_ASSERT_NEXT(a_last_rewinds, clk, rst_n, load && last, in_row_reg == '0 && out_row_reg == '0 && in_col_reg == '0)
    `SEMR_ASSERT_NOW(a_round_after_lsb, clk, rst_n, state_reg == ST_ROUND, bit_reg == 3'd7)

endmodule
